FILE: design/scoped_variable_stack_defines.svh
// ----------------------------------------------------------------------------
// scoped_variable_stack_defines
// Assertion macros used by the scoped variable stack top module.
// ----------------------------------------------------------------------------
`ifndef SCOPED_VARIABLE_STACK_DEFINES_SVH
`define SCOPED_VARIABLE_STACK_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define SVS_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define SVS_CHECK_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/svs_pkg.sv
// ----------------------------------------------------------------------------
// svs_pkg
// Types and codes of the scoped variable stack.
// ----------------------------------------------------------------------------
package svs_pkg;

    typedef enum logic [3:0] {
        C_CTXPUSH    = 4'd0,
        C_CTXPOP     = 4'd1,
        C_FRAMEPUSH  = 4'd2,
        C_FRAMEPOP   = 4'd3,
        C_VARPUSH    = 4'd4,
        C_PARAMPUSH  = 4'd5,
        C_PARAMRESET = 4'd6,
        C_MARKGLOBAL = 4'd7,
        C_FIND       = 4'd8,
        C_RESET      = 4'd9,
        C_SETLIMIT   = 4'd10
    } t_cmd;

    typedef enum logic [2:0] {
        K_CTX    = 3'd0,
        K_FRAME  = 3'd1,
        K_VAR    = 3'd2,
        K_PARAM  = 3'd3,
        K_ACTIVE = 3'd4
    } t_kind;

    // What the cells test while a probe passes
    typedef enum logic [2:0] {
        M_CTXPOP   = 3'd0,
        M_FRAMEPOP = 3'd1,
        M_FRAMECHK = 3'd2,
        M_PRESET   = 3'd3,
        M_FIND1    = 3'd4,
        M_FIND2    = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADCTX = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_SCAN = 2'd2,
        S_FIN  = 2'd3
    } t_state;

    typedef struct packed {
        logic  en;
        t_mode mode;
        logic  want;
    } t_scan_ctl;

    typedef struct packed {
        logic live;
        logic done;
        logic hit;
        logic bad;
    } t_probe;

endpackage

FILE: design/svs_cell.sv
// ----------------------------------------------------------------------------
// svs_cell
// One stack slot plus one stage of the downward probe chain.
// ----------------------------------------------------------------------------
module svs_cell #(
    parameter int AW         = 8,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [AW-1:0]         i_index,
    input  svs_pkg::t_scan_ctl    i_ctl,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [KEY_BITS-1:0]   i_elem,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  svs_pkg::t_kind        i_wkind,
    input  logic [KEY_BITS-1:0]   i_wkey,
    input  logic [VALUE_BITS-1:0] i_wval,
    input  logic                  i_inject,
    input  logic [AW-1:0]         i_start,
    input  svs_pkg::t_probe       i_prb,
    input  logic [AW-1:0]         i_prb_slot,
    input  logic [VALUE_BITS-1:0] i_prb_val,
    output svs_pkg::t_probe       o_prb,
    output logic [AW-1:0]         o_prb_slot,
    output logic [VALUE_BITS-1:0] o_prb_val
);
    import svs_pkg::*;

    t_kind                 r_kind;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    t_probe                r_prb;
    logic [AW-1:0]         r_pslot;
    logic [VALUE_BITS-1:0] r_pval;
    t_kind                 n_kind;
    logic                  w_act;
    logic                  w_keq;
    logic                  w_eeq;

    always_comb begin
        o_prb      = r_prb;
        o_prb_slot = r_pslot;
        o_prb_val  = r_pval;
        n_kind     = r_kind;
        w_act      = r_prb.live & ~r_prb.done & i_ctl.en;
        w_keq      = (r_key == i_key);
        w_eeq      = (r_key == i_elem);
        if (w_act) begin
            case (i_ctl.mode)
                M_CTXPOP: begin
                    if (r_kind == K_CTX) begin
                        o_prb.done = 1'b1;
                        o_prb.hit  = 1'b1;
                    end
                end
                M_FRAMEPOP: begin
                    if (r_kind == K_CTX) begin
                        o_prb.done = 1'b1;
                        o_prb.bad  = 1'b1;
                    end else if (r_kind == K_FRAME) begin
                        o_prb.done = 1'b1;
                        o_prb.bad  = ~w_eeq;
                    end
                end
                M_FRAMECHK: begin
                    if (r_kind == K_FRAME && w_eeq) begin
                        o_prb.done = 1'b1;
                        o_prb.hit  = 1'b1;
                    end
                end
                M_PRESET: begin
                    if (r_kind == K_CTX) begin
                        o_prb.done = 1'b1;
                    end else if (r_kind == K_ACTIVE) begin
                        n_kind = K_PARAM;
                    end
                end
                M_FIND1: begin
                    if ((r_kind == K_VAR || r_kind == K_ACTIVE) && w_keq) begin
                        o_prb.done = 1'b1;
                        o_prb.hit  = 1'b1;
                    end else if (r_kind == K_PARAM && i_ctl.want && w_keq) begin
                        o_prb.done = 1'b1;
                        o_prb.hit  = 1'b1;
                        n_kind     = K_ACTIVE;
                    end else if (r_kind == K_CTX) begin
                        o_prb.done = 1'b1;
                    end
                end
                M_FIND2: begin
                    if (r_kind == K_VAR && w_keq) begin
                        o_prb.done = 1'b1;
                        o_prb.hit  = 1'b1;
                    end else if (r_kind == K_CTX) begin
                        o_prb.done = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (o_prb.done) begin
                o_prb_slot = i_index;
                o_prb_val  = r_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && i_waddr == i_index) begin
            r_kind <= i_wkind;
            r_key  <= i_wkey;
            r_val  <= i_wval;
        end else begin
            r_kind <= n_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prb <= '0;
        end else if (i_inject && i_start == i_index) begin
            r_prb <= '{live: 1'b1, done: 1'b0, hit: 1'b0, bad: 1'b0};
        end else begin
            r_prb <= i_prb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pslot <= i_prb_slot;
        r_pval  <= i_prb_val;
    end

endmodule

FILE: design/scoped_variable_stack.sv
// ----------------------------------------------------------------------------
// scoped_variable_stack
// Scoped symbol table stack built as a row of slot cells with a probe chain.
// ----------------------------------------------------------------------------
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+------------------------------------
//  in      | i_in_valid  | o_in_stall  | i_cmd .. i_limit_value
//  out     | o_out_valid | i_out_stall | o_status .. o_depth_now
//
//  Commands without a scan pass from EXEC to FIN; the result register loads
//  as FIN returns to IDLE, and only then is the next input transfer taken.
//  A scan injects a probe at its start slot; the probe walks one cell per
//  cycle down to slot 0, and the scan ends when it comes out of slot 0. A find may
//  run two scans (frame, then global region), a varpush a scan and two pushes.
//  Reset clears control state only; slot contents are undefined until pushed.
//  The input stalls while one command is in work or its result waits.
// ----------------------------------------------------------------------------
`include "scoped_variable_stack_defines.svh"

module scoped_variable_stack #(
    parameter int STACK_DEPTH = 256,
    parameter int KEY_BITS    = 16,
    parameter int VALUE_BITS  = 32,
    localparam int AW = $clog2(STACK_DEPTH),
    localparam int CW = $clog2(STACK_DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [3:0]            i_cmd,
    input  logic [KEY_BITS-1:0]   i_name_key,
    input  logic [VALUE_BITS-1:0] i_value_handle,
    input  logic [KEY_BITS-1:0]   i_element_id,
    input  logic                  i_want_param,
    input  logic                  i_search_global,
    input  logic [CW-1:0]         i_limit_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_status,
    output logic                  o_found,
    output logic [VALUE_BITS-1:0] o_found_value,
    output logic [AW-1:0]         o_found_slot,
    output logic [CW-1:0]         o_depth_now
);
    import svs_pkg::*;

    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    // control state
    t_state    r_state, n_state;
    logic [CW-1:0] r_size, n_size;
    logic [CW-1:0] r_fl, n_fl;
    logic [CW-1:0] r_gl, n_gl;
    logic      r_gm, n_gm;
    logic [1:0] r_phase, n_phase;
    logic      r_present, n_present;
    t_scan_ctl r_ctl, n_ctl;

    // captured command
    logic [3:0]            r_cmd;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [KEY_BITS-1:0]   r_elem;
    logic                  r_wp;
    logic                  r_sg;
    logic [CW-1:0]         r_lv;

    // result in progress
    t_status               r_status, n_status;
    logic                  r_found, n_found;
    logic [VALUE_BITS-1:0] r_fval, n_fval;
    logic [AW-1:0]         r_fslot, n_fslot;

    // output register
    logic                  r_out_valid;
    logic [1:0]            r_o_status;
    logic                  r_o_found;
    logic [VALUE_BITS-1:0] r_o_fval;
    logic [AW-1:0]         r_o_fslot;
    logic [CW-1:0]         r_o_depth;

    // slot write port and probe injection
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    t_kind                 w_wkind;
    logic [KEY_BITS-1:0]   w_wkey;
    logic [VALUE_BITS-1:0] w_wval;
    logic                  w_inject;
    logic [AW-1:0]         w_start;

    logic                  p_req;
    t_kind                 p_kind;
    logic [KEY_BITS-1:0]   p_key;
    logic [VALUE_BITS-1:0] p_val;

    logic                  w_in_acc;
    logic                  w_out_free;
    logic [CW-1:0]         w_new;
    logic [CW-1:0]         w_npop;
    t_scan_ctl             w_ctl0;

    // probe chain: entry i is what cell i hands down toward slot 0
    t_probe                w_prb  [STACK_DEPTH+1];
    logic [AW-1:0]         w_slot [STACK_DEPTH+1];
    logic [VALUE_BITS-1:0] w_pval [STACK_DEPTH+1];

    assign w_prb[STACK_DEPTH]  = '0;
    assign w_slot[STACK_DEPTH] = '0;
    assign w_pval[STACK_DEPTH] = '0;

    // slot 0 is inspected only when popping to a context marker
    always_comb begin
        w_ctl0    = r_ctl;
        w_ctl0.en = r_ctl.en & (r_ctl.mode == M_CTXPOP);
    end

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        svs_cell #(
            .AW         (AW),
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_index    (AW'(g)),
            .i_ctl      ((g == 0) ? w_ctl0 : r_ctl),
            .i_key      (r_key),
            .i_elem     (r_elem),
            .i_we       (w_we),
            .i_waddr    (w_waddr),
            .i_wkind    (w_wkind),
            .i_wkey     (w_wkey),
            .i_wval     (w_wval),
            .i_inject   (w_inject),
            .i_start    (w_start),
            .i_prb      (w_prb[g+1]),
            .i_prb_slot (w_slot[g+1]),
            .i_prb_val  (w_pval[g+1]),
            .o_prb      (w_prb[g]),
            .o_prb_slot (w_slot[g]),
            .o_prb_val  (w_pval[g])
        );
    end

    // frame limit after popping from old_sz down to new_sz
    function automatic logic [CW-1:0] f_fl_after(
        input logic [CW-1:0] fl,
        input logic [CW-1:0] old_sz,
        input logic [CW-1:0] new_sz
    );
        return (fl >= new_sz && fl <= old_sz) ? new_sz : fl;
    endfunction

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid & ~o_in_stall;
    assign w_out_free = ~r_out_valid | ~i_out_stall;

    always_comb begin
        n_state   = r_state;
        n_size    = r_size;
        n_fl      = r_fl;
        n_gl      = r_gl;
        n_gm      = r_gm;
        n_phase   = r_phase;
        n_present = r_present;
        n_ctl     = r_ctl;
        n_status  = r_status;
        n_found   = r_found;
        n_fval    = r_fval;
        n_fslot   = r_fslot;
        w_we      = 1'b0;
        w_waddr   = r_size[AW-1:0];
        w_wkind   = K_CTX;
        w_wkey    = '0;
        w_wval    = '0;
        w_inject  = 1'b0;
        w_start   = '0;
        p_req     = 1'b0;
        p_kind    = K_CTX;
        p_key     = '0;
        p_val     = '0;
        w_new     = '0;
        w_npop    = '0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state   = S_EXEC;
                    n_phase   = '0;
                    n_present = 1'b0;
                    n_status  = ST_OK;
                    n_found   = 1'b0;
                    n_fval    = '0;
                    n_fslot   = '0;
                end
            end
            S_EXEC: begin
                n_state = S_FIN;
                case (r_cmd)
                    C_CTXPUSH, C_FRAMEPUSH, C_PARAMPUSH: begin
                        p_req  = 1'b1;
                        p_kind = (r_cmd == C_CTXPUSH) ? K_CTX :
                                 (r_cmd == C_FRAMEPUSH) ? K_FRAME : K_PARAM;
                        p_key  = (r_cmd == C_CTXPUSH) ? '0 :
                                 (r_cmd == C_FRAMEPUSH) ? r_elem : r_key;
                        p_val  = (r_cmd == C_PARAMPUSH) ? r_val : '0;
                    end
                    C_CTXPOP: begin
                        if (r_size != '0) begin
                            w_inject   = 1'b1;
                            w_start    = AW'(r_size - 1'b1);
                            n_ctl.en   = 1'b1;
                            n_ctl.mode = M_CTXPOP;
                            n_state    = S_SCAN;
                        end
                    end
                    C_FRAMEPOP: begin
                        if (r_fl > CW'(1)) begin
                            w_inject   = 1'b1;
                            w_start    = AW'(r_fl - 1'b1);
                            n_ctl.en   = 1'b1;
                            n_ctl.mode = M_FRAMEPOP;
                            n_state    = S_SCAN;
                        end
                    end
                    C_VARPUSH: begin
                        case (r_phase)
                            2'd0: begin
                                // look for a frame marker of this element
                                if (r_size > CW'(1)) begin
                                    w_inject   = 1'b1;
                                    w_start    = AW'(r_size - 1'b1);
                                    n_ctl.en   = 1'b1;
                                    n_ctl.mode = M_FRAMECHK;
                                    n_state    = S_SCAN;
                                end else begin
                                    n_phase = 2'd1;
                                    n_state = S_EXEC;
                                end
                            end
                            2'd1: begin
                                p_req = 1'b1;
                                if (r_present) begin
                                    p_kind = K_VAR;
                                    p_key  = r_key;
                                    p_val  = r_val;
                                end else begin
                                    p_kind  = K_FRAME;
                                    p_key   = r_elem;
                                    n_phase = 2'd2;
                                    n_state = S_EXEC;
                                end
                            end
                            default: begin
                                p_req  = 1'b1;
                                p_kind = K_VAR;
                                p_key  = r_key;
                                p_val  = r_val;
                            end
                        endcase
                    end
                    C_PARAMRESET: begin
                        if (r_fl > CW'(1)) begin
                            w_inject   = 1'b1;
                            w_start    = AW'(r_fl - 1'b1);
                            n_ctl.en   = 1'b1;
                            n_ctl.mode = M_PRESET;
                            n_state    = S_SCAN;
                        end
                    end
                    C_MARKGLOBAL: begin
                        n_gl   = r_size;
                        n_gm   = 1'b1;
                        p_req  = 1'b1;
                        p_kind = K_CTX;
                    end
                    C_FIND: begin
                        if (r_phase == 2'd0) begin
                            if (r_fl > CW'(1)) begin
                                w_inject   = 1'b1;
                                w_start    = AW'(r_fl - 1'b1);
                                n_ctl.en   = 1'b1;
                                n_ctl.mode = M_FIND1;
                                n_ctl.want = r_wp;
                                n_state    = S_SCAN;
                            end else begin
                                n_phase = 2'd1;
                                n_state = S_EXEC;
                            end
                        end else if (!r_wp && r_sg && r_gl > CW'(1)) begin
                            // fall back to the global region
                            w_inject   = 1'b1;
                            w_start    = AW'(r_gl - 1'b1);
                            n_ctl.en   = 1'b1;
                            n_ctl.mode = M_FIND2;
                            n_state    = S_SCAN;
                        end
                    end
                    C_RESET: begin
                        n_fl   = f_fl_after(r_fl, r_size, '0);
                        n_size = '0;
                        n_gm   = 1'b0;
                    end
                    C_SETLIMIT: begin
                        n_fl = (r_lv > DEPTH_C) ? DEPTH_C : r_lv;
                    end
                    default: begin
                    end
                endcase

                // common push path; a full stack drops the entry
                if (p_req) begin
                    if (r_size >= DEPTH_C) begin
                        n_status = ST_FULL;
                        n_state  = S_FIN;
                    end else begin
                        w_we    = 1'b1;
                        w_wkind = p_kind;
                        w_wkey  = p_key;
                        w_wval  = p_val;
                        n_fl    = (r_fl == r_size) ? r_fl + 1'b1 : r_fl;
                        n_size  = r_size + 1'b1;
                        if (!r_gm && p_kind == K_VAR) begin
                            n_gl = n_fl;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (w_prb[0].live) begin
                    n_ctl.en = 1'b0;
                    n_state  = S_FIN;
                    case (r_cmd)
                        C_CTXPOP: begin
                            w_new  = w_prb[0].hit ? CW'(w_slot[0]) : '0;
                            n_fl   = f_fl_after(r_fl, r_size, w_new);
                            n_size = w_new;
                        end
                        C_FRAMEPOP: begin
                            // each inspected entry pops the top once
                            w_npop = r_fl - (w_prb[0].done ? CW'(w_slot[0]) : CW'(1));
                            w_new  = (r_size > w_npop) ? r_size - w_npop : '0;
                            n_fl   = f_fl_after(r_fl, r_size, w_new);
                            n_size = w_new;
                            if (w_prb[0].bad) begin
                                n_status = ST_BADCTX;
                            end
                        end
                        C_VARPUSH: begin
                            n_present = w_prb[0].hit;
                            n_phase   = 2'd1;
                            n_state   = S_EXEC;
                        end
                        C_FIND: begin
                            if (w_prb[0].hit) begin
                                n_found = 1'b1;
                                n_fval  = w_pval[0];
                                n_fslot = w_slot[0];
                            end else if (r_phase == 2'd0) begin
                                n_phase = 2'd1;
                                n_state = S_EXEC;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= '0;
            r_fl        <= '0;
            r_gl        <= '0;
            r_gm        <= 1'b0;
            r_phase     <= '0;
            r_present   <= 1'b0;
            r_ctl       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_size    <= n_size;
            r_fl      <= n_fl;
            r_gl      <= n_gl;
            r_gm      <= n_gm;
            r_phase   <= n_phase;
            r_present <= n_present;
            r_ctl     <= n_ctl;
            if (r_state == S_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_found  <= n_found;
        r_fval   <= n_fval;
        r_fslot  <= n_fslot;
        if (w_in_acc) begin
            r_cmd  <= i_cmd;
            r_key  <= i_name_key;
            r_val  <= i_value_handle;
            r_elem <= i_element_id;
            r_wp   <= i_want_param;
            r_sg   <= i_search_global;
            r_lv   <= i_limit_value;
        end
        if (r_state == S_FIN && w_out_free) begin
            r_o_status <= r_status;
            r_o_found  <= r_found;
            r_o_fval   <= r_fval;
            r_o_fslot  <= r_fslot;
            r_o_depth  <= r_size;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_found       = r_o_found;
    assign o_found_value = r_o_fval;
    assign o_found_slot  = r_o_fslot;
    assign o_depth_now   = r_o_depth;

    `SVS_CHECK(a_size_range, r_size <= DEPTH_C, "stack size beyond depth")
    `SVS_CHECK(a_fl_range, r_fl <= DEPTH_C, "frame limit beyond depth")
    `SVS_CHECK(a_probe_in_scan, w_prb[0].live |-> r_state == S_SCAN, "probe exit outside scan")
    `SVS_CHECK_NEXT(a_fin_loads, r_state == S_FIN && w_out_free, r_out_valid && r_state == S_IDLE, "result not loaded")

endmodule

FILE: sim/scoped_variable_stack_test.sv
// ----------------------------------------------------------------------------
// scoped_variable_stack_test
// Self-checking bench for the scoped variable stack: a scoreboard class keeps
// its own copy of the stack, predicts one result per accepted command and
// checks every output transfer in order, under random idling on both sides.
// ----------------------------------------------------------------------------
module scoped_variable_stack_test;
    timeunit 1ns;
    timeprecision 1ps;
    import svs_pkg::*;

    localparam int DEPTH = 256;

    typedef struct {
        logic [3:0]  cmd;
        logic [15:0] key;
        logic [31:0] val;
        logic [15:0] elem;
        logic        want;
        logic        glob;
        logic [8:0]  lim;
    } t_cmd_item;

    typedef struct {
        logic [1:0]  status;
        logic        found;
        logic [31:0] value;
        logic [7:0]  slot;
        logic [8:0]  depth;
    } t_stack_result;

    // Scoreboard: shadow copy of the symbol stack plus the queue of results
    // still owed by the block.
    class t_scoreboard;
        t_kind       kind_mem [DEPTH];
        logic [15:0] key_mem  [DEPTH];
        logic [31:0] val_mem  [DEPTH];
        int          size, flim, glim, written;
        bit          gmark;
        t_stack_result owed_q[$];
        int          errors, checked, hits, fulls, badctx;
        int          cmd_seen [16];

        function void clear();
            size = 0; flim = 0; glim = 0; gmark = 0; written = 0;
        endfunction

        task report(input string msg);
            $display("MISMATCH %0s (result %0d)", msg, checked);
            errors++;
        endtask

        function bit push(t_kind k, logic [15:0] key, logic [31:0] val);
            if (size >= DEPTH) return 0;
            if (flim == size) flim++;
            kind_mem[size] = k;
            key_mem[size]  = key;
            val_mem[size]  = val;
            size++;
            if (size > written) written = size;
            if (!gmark && k == K_VAR) glim = flim;
            return 1;
        endfunction

        function void pop();
            if (size == 0) return;
            if (flim == size) flim--;
            size--;
        endfunction

        function bit frame_here(logic [15:0] elem);
            for (int i = size; i > 1; i--)
                if (kind_mem[i-1] == K_FRAME && key_mem[i-1] == elem) return 1;
            return 0;
        endfunction

        // Predict the result of one accepted command and queue it.
        function void note_input(t_cmd_item it);
            t_stack_result r;
            t_kind k;
            logic [15:0] e;
            int lim;
            r = '{default: 0};
            cmd_seen[it.cmd]++;
            case (it.cmd)
                C_CTXPUSH:   if (!push(K_CTX, 0, 0)) r.status = ST_FULL;
                C_CTXPOP: begin
                    while (size > 0) begin
                        k = kind_mem[size-1];
                        pop();
                        if (k == K_CTX) break;
                    end
                end
                C_FRAMEPUSH: if (!push(K_FRAME, it.elem, 0)) r.status = ST_FULL;
                C_FRAMEPOP: begin
                    // every inspected slot costs one pop of the top entry
                    lim = flim;
                    for (int i = lim; i > 1; i--) begin
                        k = kind_mem[i-1];
                        e = key_mem[i-1];
                        pop();
                        if (k == K_CTX) begin
                            r.status = ST_BADCTX;
                            break;
                        end
                        if (k == K_FRAME) begin
                            if (e != it.elem) r.status = ST_BADCTX;
                            break;
                        end
                    end
                end
                C_VARPUSH: begin
                    if (!frame_here(it.elem) && !push(K_FRAME, it.elem, 0))
                        r.status = ST_FULL;
                    else if (!push(K_VAR, it.key, it.val))
                        r.status = ST_FULL;
                end
                C_PARAMPUSH: if (!push(K_PARAM, it.key, it.val)) r.status = ST_FULL;
                C_PARAMRESET: begin
                    for (int i = flim; i > 1; i--) begin
                        if (kind_mem[i-1] == K_CTX) break;
                        if (kind_mem[i-1] == K_ACTIVE) kind_mem[i-1] = K_PARAM;
                    end
                end
                C_MARKGLOBAL: begin
                    glim = size;
                    gmark = 1;
                    if (!push(K_CTX, 0, 0)) r.status = ST_FULL;
                end
                C_FIND: begin
                    for (int i = flim; i > 1; i--) begin
                        k = kind_mem[i-1];
                        if (k == K_VAR || k == K_ACTIVE) begin
                            if (key_mem[i-1] == it.key) begin
                                r.found = 1; r.slot = 8'(i - 1); break;
                            end
                        end else if (k == K_PARAM) begin
                            if (it.want && key_mem[i-1] == it.key) begin
                                kind_mem[i-1] = K_ACTIVE;
                                r.found = 1; r.slot = 8'(i - 1); break;
                            end
                        end else if (k == K_CTX) begin
                            break;
                        end
                    end
                    // global region only for plain variable lookups
                    if (!r.found && !it.want && it.glob && glim > 1) begin
                        lim = glim > DEPTH ? DEPTH : glim;
                        for (int i = lim; i > 1; i--) begin
                            k = kind_mem[i-1];
                            if (k == K_VAR && key_mem[i-1] == it.key) begin
                                r.found = 1; r.slot = 8'(i - 1); break;
                            end
                            if (k == K_CTX) break;
                        end
                    end
                    if (r.found) begin
                        r.value = val_mem[r.slot];
                        hits++;
                    end
                end
                C_RESET: begin
                    while (size > 0) pop();
                    gmark = 0;
                end
                C_SETLIMIT: flim = it.lim > DEPTH ? DEPTH : it.lim;
                default: ;
            endcase
            if (r.status == ST_FULL) fulls++;
            if (r.status == ST_BADCTX) badctx++;
            r.depth = 9'(size);
            owed_q.insert(owed_q.size(), r);
        endfunction

        function bit scan_safe(int lim);
            return lim <= written;
        endfunction

        task check_result(t_stack_result got);
            t_stack_result w;
            if (owed_q.size() == 0) begin
                report("unexpected result transfer");
                return;
            end
            w = owed_q.pop_front();
            if (got.status !== w.status)
                report($sformatf("status: got %0h want %0h", got.status, w.status));
            if (got.found !== w.found)
                report($sformatf("found: got %0h want %0h", got.found, w.found));
            if (got.value !== w.value)
                report($sformatf("found_value: got %0h want %0h", got.value, w.value));
            if (got.slot !== w.slot)
                report($sformatf("found_slot: got %0h want %0h", got.slot, w.slot));
            if (got.depth !== w.depth)
                report($sformatf("depth_now: got %0h want %0h", got.depth, w.depth));
            checked++;
        endtask
    endclass

    logic        i_clk, i_rst_n;
    logic        i_in_valid, o_in_stall;
    logic [3:0]  i_cmd;
    logic [15:0] i_name_key, i_element_id;
    logic [31:0] i_value_handle;
    logic        i_want_param, i_search_global;
    logic [8:0]  i_limit_value;
    logic        o_out_valid, i_out_stall;
    logic [1:0]  o_status;
    logic        o_found;
    logic [31:0] o_found_value;
    logic [7:0]  o_found_slot;
    logic [8:0]  o_depth_now;

    t_scoreboard board = new();
    int idle_in, idle_out;   // idle percentages of sender and receiver
    int hold_req;            // long receiver hold-off, in cycles

    scoped_variable_stack dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_cmd(i_cmd), .i_name_key(i_name_key), .i_value_handle(i_value_handle),
        .i_element_id(i_element_id), .i_want_param(i_want_param),
        .i_search_global(i_search_global), .i_limit_value(i_limit_value),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_status(o_status), .o_found(o_found), .o_found_value(o_found_value),
        .o_found_slot(o_found_slot), .o_depth_now(o_depth_now)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stall, or a counted hold-off when one is requested.
    initial begin
        int hold_left;
        hold_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < idle_out);
            end
        end
    end

    // Output monitor: every result transfer goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_result('{o_status, o_found, o_found_value,
                                 o_found_slot, o_depth_now});
    end

    initial begin
        #50ms;
        $display("scoped_variable_stack verification failed");
        $finish;
    end

    // Keep scans on written slots only: a scan from above the highest slot
    // ever pushed would read an unwritten entry, so such a command becomes a
    // setlimit back into the written range, or a find drops its global search.
    function automatic t_cmd_item make_safe(t_cmd_item it);
        int gl;
        if ((it.cmd == C_FIND || it.cmd == C_FRAMEPOP || it.cmd == C_PARAMRESET)
                && !board.scan_safe(board.flim)) begin
            it.cmd = C_SETLIMIT;
            it.lim = 9'($urandom_range(board.written));
        end
        gl = board.glim > DEPTH ? DEPTH : board.glim;
        if (it.cmd == C_FIND && !it.want && it.glob && board.glim > 1
                && !board.scan_safe(gl))
            it.glob = 1'b0;
        return it;
    endfunction

    // One input transfer; valid only drops when the sender chooses to idle.
    task automatic send(input t_cmd_item it);
        it = make_safe(it);
        while ($urandom_range(99) < idle_in) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_cmd           <= it.cmd;
        i_name_key      <= it.key;
        i_value_handle  <= it.val;
        i_element_id    <= it.elem;
        i_want_param    <= it.want;
        i_search_global <= it.glob;
        i_limit_value   <= it.lim;
        do @(posedge i_clk); while (o_in_stall);
        board.note_input(it);
    endtask

    task automatic send_cmd(input logic [3:0] c, input logic [15:0] key = 0,
                            input logic [15:0] elem = 0, input logic want = 0,
                            input logic glob = 0, input logic [8:0] lim = 0,
                            input logic [31:0] val = 32'h0);
        t_cmd_item it;
        it = '{c, key, val, elem, want, glob, lim};
        send(it);
    endtask

    // Narrow keys most of the time so lookups and frame checks actually hit.
    function automatic logic [15:0] pick_name();
        return ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                        : 16'($urandom_range(3));
    endfunction

    function automatic t_cmd_item random_item();
        t_cmd_item it;
        int r;
        r = $urandom_range(99);
        it.key  = pick_name();
        it.elem = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                           : 16'($urandom_range(2));
        it.val  = $urandom;
        it.want = 1'($urandom_range(1));
        it.glob = 1'($urandom_range(1));
        it.lim  = ($urandom_range(3) == 0) ? 9'($urandom_range(256))
                                           : 9'($urandom_range(board.size));
        if      (r < 8)  it.cmd = C_CTXPUSH;
        else if (r < 12) it.cmd = C_CTXPOP;
        else if (r < 20) it.cmd = C_FRAMEPUSH;
        else if (r < 26) it.cmd = C_FRAMEPOP;
        else if (r < 44) it.cmd = C_VARPUSH;
        else if (r < 52) it.cmd = C_PARAMPUSH;
        else if (r < 56) it.cmd = C_PARAMRESET;
        else if (r < 59) it.cmd = C_MARKGLOBAL;
        else if (r < 84) it.cmd = C_FIND;
        else if (r < 86) it.cmd = C_RESET;
        else if (r < 93) it.cmd = C_SETLIMIT;
        else if (r < 96) it.cmd = 4'($urandom_range(11, 15));  // ignored codes
        else             it.cmd = C_CTXPUSH;
        return it;
    endfunction

    // Fill to the top and beyond so full-stack drops and deep scans happen.
    task automatic fill_stack();
        while (board.size < DEPTH) begin
            if ($urandom_range(3) == 0)
                send_cmd(C_PARAMPUSH, pick_name(), 0, 0, 0, 0, $urandom);
            else
                send_cmd(C_VARPUSH, pick_name(), 16'd1, 0, 0, 0, $urandom);
        end
        send_cmd(C_VARPUSH, 16'd1, 16'd9, 0, 0, 0, 32'h1234);   // no room for frame
        send_cmd(C_PARAMPUSH, 16'd2, 0, 0, 0, 0, 32'h5678);
        send_cmd(C_MARKGLOBAL);
        send_cmd(C_CTXPUSH);
        repeat (4) send_cmd(C_FIND, pick_name(), 0, 1'($urandom_range(1)), 1);
        send_cmd(C_RESET);
    endtask

    initial begin
        int settle;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_cmd = '0; i_name_key = '0; i_value_handle = '0; i_element_id = '0;
        i_want_param = 1'b0; i_search_global = 1'b0; i_limit_value = '0;
        hold_req = 0;
        idle_in = 18;
        idle_out = 62;
        board.clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-stack pops, frame errors, param activation, globals.
        send_cmd(C_CTXPOP);
        send_cmd(C_FRAMEPOP, 0, 16'd5);
        send_cmd(C_FIND, 16'd1, 0, 0, 1);
        send_cmd(C_CTXPUSH);
        send_cmd(C_VARPUSH, 16'hFFFF, 16'hFFFF, 0, 0, 0, 32'hFFFF_FFFF);
        send_cmd(C_VARPUSH, 16'h0000, 16'hFFFF, 0, 0, 0, 32'h0);
        send_cmd(C_MARKGLOBAL);
        send_cmd(C_FRAMEPUSH, 0, 16'h00A5);
        send_cmd(C_VARPUSH, 16'd7, 16'h00A5, 0, 0, 0, 32'hA5A5_0001);
        send_cmd(C_PARAMPUSH, 16'd5, 0, 0, 0, 0, 32'h0000_5555);
        send_cmd(C_FIND, 16'd5, 0, 0, 0);           // inactive param is skipped
        send_cmd(C_FIND, 16'd5, 0, 1, 0);           // activates it
        send_cmd(C_FIND, 16'd5, 0, 0, 0);           // active param now matches
        send_cmd(C_PARAMRESET);
        send_cmd(C_FIND, 16'hFFFF, 0, 0, 1);        // from the global region
        send_cmd(C_FIND, 16'hFFFF, 0, 1, 1);        // want_param blocks global
        send_cmd(C_FRAMEPOP, 0, 16'h0077);          // wrong element
        send_cmd(C_FRAMEPOP, 0, 16'h0001);          // runs into context marker
        send_cmd(C_SETLIMIT, 0, 0, 0, 0, 9'd256);   // limit at the full depth, above the stack
        send_cmd(C_SETLIMIT, 0, 0, 0, 0, 9'd0);
        send_cmd(4'd11);
        send_cmd(4'd15);
        send_cmd(C_RESET);
        send_cmd(C_FIND, 16'hFFFF, 0, 0, 1);        // global_limit survives reset

        for (int n = 0; n < 1700; n++) begin
            if (n == 700) begin
                idle_in = 62;
                idle_out = 18;
            end
            if (n == 1400) begin
                idle_in = 0;
                idle_out = 0;
            end
            if (n == 300 || n == 1500) hold_req = 400;
            if (n == 1000) begin
                // drop valid so the last item is not offered again
                i_in_valid <= 1'b0;
                while (board.owed_q.size() != 0) @(posedge i_clk);
            end
            if (n == 450) fill_stack();
            send(random_item());
        end
        i_in_valid <= 1'b0;

        settle = 0;
        while (board.owed_q.size() != 0 && settle < 200000) begin
            @(posedge i_clk);
            settle++;
        end
        repeat (600) @(posedge i_clk);

        $display("Covered %0d results: %0d lookups (%0d hits), %0d frame pops, %0d resets,",
                 board.checked, board.cmd_seen[C_FIND], board.hits,
                 board.cmd_seen[C_FRAMEPOP], board.cmd_seen[C_RESET]);
        $display("  %0d full-stack drops and %0d bad-context errors.",
                 board.fulls, board.badctx);
        if (board.errors == 0 && board.owed_q.size() == 0) begin
            $display("scoped_variable_stack verification clean");
        end else begin
            if (board.owed_q.size() != 0)
                board.report($sformatf("%0d results never arrived",
                                       board.owed_q.size()));
            $display("scoped_variable_stack verification failed");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+design
design/svs_pkg.sv
design/svs_cell.sv
design/scoped_variable_stack.sv
sim/scoped_variable_stack_test.sv
